FILE: rtl/core/mst_pkg.sv
// Shared types and constants for the multi-slot software timer.
package mst_pkg;

  // Input action codes.
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_ALLOC = 3'd1;
  localparam logic [2:0] ACT_FREE  = 3'd2;
  localparam logic [2:0] ACT_BIND  = 3'd3;
  localparam logic [2:0] ACT_ARM   = 3'd4;

  // Result kind codes.
  localparam logic [2:0] KIND_ACK    = 3'd0;
  localparam logic [2:0] KIND_ALLOC  = 3'd1;
  localparam logic [2:0] KIND_FAIL   = 3'd2;
  localparam logic [2:0] KIND_EXPIRY = 3'd3;
  localparam logic [2:0] KIND_SWITCH = 3'd4;

  // Slot status codes.
  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_ARMED = 2'd2;

  // Result limit per tick and the width of its counter.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [4:0] NO_SWITCH = 5'd16;

  // Source of a result pushed into the output register.
  typedef enum logic [2:0] {
    PUSH_ACK,
    PUSH_ALLOCATED,
    PUSH_FAILED,
    PUSH_PEND,
    PUSH_SWITCH
  } push_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      take;
    logic      tick_inc;
    logic      tick_clr;
    logic      scan_clr;
    logic      scan_en;
    logic      do_free;
    logic      do_bind;
    logic      do_arm;
    logic      do_alloc;
    logic      expire_best;
    logic      load_pend;
    logic      set_sw;
    logic      push;
    push_sel_t push_sel;
    logic      push_last;
  } mst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] action;
    logic       slot_ok;
    logic       idx_last;
    logic       idx_free;
    logic       found;
    logic       best_is_sw;
    logic       pend_valid;
    logic       sw;
    logic       cnt_full;
    logic       out_free;
  } mst_sts_t;

endpackage

FILE: rtl/core/mst_datapath.sv
// Datapath of the timer bank: slot state, memories, scan logic and output register.
module mst_datapath import mst_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  mst_cmd_t    cmd,
  output mst_sts_t    sts,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic [2:0]  action,
  input  logic [3:0]  slot,
  input  logic [3:0]  queue_id,
  input  logic [31:0] payload,
  input  logic [31:0] delay,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [3:0]  slot_out,
  output logic [3:0]  queue_out,
  output logic [31:0] payload_out,
  output logic        last
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Captured transaction fields.
  logic [2:0]  act_q;
  logic [3:0]  slot_q;
  logic [3:0]  queue_q;
  logic [31:0] payload_q;
  logic [31:0] delay_q;

  logic [4:0]  switch_slot;
  logic [31:0] tick_count;

  logic [1:0]    slot_status      [SLOTS];
  logic [1:0]    slot_status_next [SLOTS];
  logic [SW-1:0] arm_order        [SLOTS];
  logic [SW-1:0] arm_order_next   [SLOTS];

  logic [31:0] dl_mem [SLOTS];
  logic [31:0] pl_mem [SLOTS];
  logic [3:0]  qu_mem [SLOTS];

  logic [SW-1:0] idx;
  logic          cand_v;
  logic [SW-1:0] cand_idx;
  logic [31:0]   cand_dl;
  logic          found;
  logic [SW-1:0] best;
  logic [31:0]   best_dl;
  logic [SW-1:0] best_ord;
  logic [31:0]   rd_pl;
  logic [3:0]    rd_qu;

  logic          pend_valid;
  logic [SW-1:0] pend_slot;
  logic [3:0]    pend_q;
  logic [31:0]   pend_p;
  logic          sw;
  logic [SW-1:0] sw_slot;
  logic [CNT_W-1:0] cnt;

  logic [SW-1:0] slot_idx;
  logic [SW-1:0] tgt;
  logic          tgt_armed;
  logic [SW-1:0] tgt_ord;
  logic          elig;
  logic          better;

  assign slot_idx = SW'(slot_q);

  // Status toward the controller.
  always_comb begin
    sts.action     = act_q;
    sts.slot_ok    = 32'(slot_q) < 32'(SLOTS);
    sts.idx_last   = idx == SW'(SLOTS - 1);
    sts.idx_free   = slot_status[idx] == ST_FREE;
    sts.found      = found;
    sts.best_is_sw = 32'(best) == 32'(switch_slot);
    sts.pend_valid = pend_valid;
    sts.sw         = sw;
    sts.cnt_full   = 32'(cnt) >= MAX_RESULTS;
    sts.out_free   = !out_valid || out_ready;
  end

  // Next slot status and recency ranks for free, arm, allocate and expiry.
  always_comb begin
    tgt = slot_idx;
    if (cmd.do_alloc) begin
      tgt = idx;
    end
    if (cmd.expire_best) begin
      tgt = best;
    end
    tgt_armed = slot_status[tgt] == ST_ARMED;
    tgt_ord   = arm_order[tgt];
    for (int i = 0; i < SLOTS; i++) begin
      slot_status_next[i] = slot_status[i];
      arm_order_next[i]   = arm_order[i];
      if (SW'(i) == tgt) begin
        if (cmd.do_free) begin
          slot_status_next[i] = ST_FREE;
          arm_order_next[i]   = '0;
        end else if (cmd.do_arm) begin
          slot_status_next[i] = ST_ARMED;
          arm_order_next[i]   = '0;
        end else if (cmd.do_alloc || cmd.expire_best) begin
          slot_status_next[i] = ST_ALLOC;
          arm_order_next[i]   = '0;
        end
      end else if ((cmd.do_free || cmd.do_arm || cmd.expire_best) &&
                   slot_status[i] == ST_ARMED) begin
        arm_order_next[i] = arm_order[i]
                          - SW'(tgt_armed && (arm_order[i] > tgt_ord))
                          + SW'(cmd.do_arm);
      end
    end
  end

  // Candidate comparison during a deadline scan.
  always_comb begin
    elig   = cand_v && (slot_status[cand_idx] == ST_ARMED) && (cand_dl <= tick_count);
    better = !found || (cand_dl < best_dl) ||
             ((cand_dl == best_dl) && (arm_order[cand_idx] < best_ord));
  end

  // Control state of the slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_slot <= NO_SWITCH;
      tick_count  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_status[i] <= ST_FREE;
        arm_order[i]   <= '0;
      end
      cand_v     <= 1'b0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      sw         <= 1'b0;
      cnt        <= '0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        switch_slot <= cfg_wdata;
      end
      if (cmd.tick_inc) begin
        tick_count <= tick_count + 32'd1;
      end
      slot_status <= slot_status_next;
      arm_order   <= arm_order_next;
      // Scan sequencing.
      cand_v <= cmd.scan_en;
      if (cmd.scan_clr) begin
        idx   <= '0;
        found <= 1'b0;
      end else begin
        if (cmd.scan_en) begin
          idx <= idx + SW'(1);
        end
        if (elig && better) begin
          found <= 1'b1;
        end
      end
      // Per-tick bookkeeping.
      if (cmd.tick_clr) begin
        pend_valid <= 1'b0;
        sw         <= 1'b0;
        cnt        <= '0;
      end else begin
        if (cmd.load_pend) begin
          pend_valid <= 1'b1;
        end else if (cmd.push && cmd.push_sel == PUSH_PEND) begin
          pend_valid <= 1'b0;
        end
        if (cmd.set_sw) begin
          sw <= 1'b1;
        end
        if (cmd.load_pend || cmd.set_sw) begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      // Output register.
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_q     <= action;
      slot_q    <= slot;
      queue_q   <= queue_id;
      payload_q <= payload;
      delay_q   <= delay;
    end
    cand_idx <= idx;
    if (elig && better) begin
      best     <= cand_idx;
      best_dl  <= cand_dl;
      best_ord <= arm_order[cand_idx];
    end
    if (cmd.load_pend) begin
      pend_slot <= best;
      pend_q    <= rd_qu;
      pend_p    <= rd_pl;
    end
    if (cmd.set_sw) begin
      sw_slot <= best;
    end
    if (cmd.push) begin
      last <= cmd.push_last;
      unique case (cmd.push_sel)
        PUSH_ACK: begin
          kind <= KIND_ACK; slot_out <= '0; queue_out <= '0; payload_out <= '0;
        end
        PUSH_ALLOCATED: begin
          kind <= KIND_ALLOC; slot_out <= 4'(idx); queue_out <= '0; payload_out <= '0;
        end
        PUSH_FAILED: begin
          kind <= KIND_FAIL; slot_out <= '0; queue_out <= '0; payload_out <= '0;
        end
        PUSH_PEND: begin
          kind <= KIND_EXPIRY; slot_out <= 4'(pend_slot);
          queue_out <= pend_q; payload_out <= pend_p;
        end
        PUSH_SWITCH: begin
          kind <= KIND_SWITCH; slot_out <= 4'(sw_slot); queue_out <= '0; payload_out <= '0;
        end
        default: begin
          kind <= KIND_ACK; slot_out <= '0; queue_out <= '0; payload_out <= '0;
        end
      endcase
    end
  end

  // Deadline memory: written on arm, read by the scan.
  always_ff @(posedge clk) begin
    if (cmd.do_arm) begin
      dl_mem[slot_idx] <= delay_q + tick_count;
    end
    cand_dl <= dl_mem[idx];
  end

  // Queue and payload memories: written on bind, read at the chosen slot.
  always_ff @(posedge clk) begin
    if (cmd.do_bind) begin
      pl_mem[slot_idx] <= payload_q;
      qu_mem[slot_idx] <= queue_q;
    end
    rd_pl <= pl_mem[best];
    rd_qu <= qu_mem[best];
  end

`ifndef SYNTHESIS
  // Checks on the per-tick bookkeeping.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= MAX_RESULTS)
    else $error("result count exceeded the per-tick limit");
  a_pend_flushed: assert property (@(posedge clk) disable iff (rst)
    cmd.load_pend |-> !pend_valid)
    else $error("pending expiry overwritten before it was sent");
  a_expire_found: assert property (@(posedge clk) disable iff (rst)
    cmd.expire_best |-> found && slot_status[best] == ST_ARMED)
    else $error("expiry of a slot that is not armed");
`endif

endmodule

FILE: rtl/core/mst_ctrl.sv
// Controller state machine of the timer bank.
module mst_ctrl import mst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  mst_sts_t sts,
  output mst_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RESP, S_ALLOC, S_CHECK, S_SCAN,
    S_DRAIN, S_DECIDE, S_FLUSH, S_LOAD, S_END
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  // Commands and next state.
  always_comb begin
    cmd            = '0;
    cmd.push_sel   = PUSH_ACK;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.action == ACT_TICK) begin
          cmd.tick_inc = 1'b1;
          cmd.tick_clr = 1'b1;
          state_next   = S_CHECK;
        end else if (sts.action == ACT_ALLOC) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_ALLOC;
        end else begin
          cmd.do_free = sts.slot_ok && sts.action == ACT_FREE;
          cmd.do_bind = sts.slot_ok && sts.action == ACT_BIND;
          cmd.do_arm  = sts.slot_ok && sts.action == ACT_ARM;
          state_next  = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_sel  = PUSH_ACK;
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_ALLOC: begin
        if (sts.idx_free || sts.idx_last) begin
          if (sts.out_free) begin
            cmd.push      = 1'b1;
            cmd.push_last = 1'b1;
            cmd.push_sel  = sts.idx_free ? PUSH_ALLOCATED : PUSH_FAILED;
            cmd.do_alloc  = sts.idx_free;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts.cnt_full) begin
          state_next = S_END;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.idx_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.found) begin
          state_next = S_END;
        end else if (sts.best_is_sw) begin
          cmd.expire_best = 1'b1;
          cmd.set_sw      = 1'b1;
          state_next      = S_CHECK;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = S_LOAD;
        end else if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.push_sel = PUSH_PEND;
          state_next   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_pend   = 1'b1;
        cmd.expire_best = 1'b1;
        state_next      = S_CHECK;
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          if (sts.pend_valid) begin
            cmd.push_sel  = PUSH_PEND;
            cmd.push_last = !sts.sw;
            state_next    = sts.sw ? S_END : S_IDLE;
          end else if (sts.sw) begin
            cmd.push_sel  = PUSH_SWITCH;
            cmd.push_last = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.push_sel  = PUSH_ACK;
            cmd.push_last = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // Checks on command sequencing.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> sts.out_free)
    else $error("result pushed while the output register is full");
  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_free, cmd.do_bind, cmd.do_arm, cmd.do_alloc, cmd.expire_best}))
    else $error("two slot updates in one cycle");
  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> state == S_EXEC && !in_ready)
    else $error("accepted transaction not executed");
`endif

endmodule

FILE: rtl/core/multi_slot_software_timer.sv
// Top level of the multi-slot software timer bank.
// Free, bind, arm and unknown actions each produce a single result.
// Allocate scans slot status one slot per cycle.
// A tick scans once per expiry, including the switch slot, then scans once more while
// fewer than 16 results are counted.
// Synchronous reset frees all slots, clears the count and sets no switch slot.
module multi_slot_software_timer import mst_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [3:0]  slot,
  input  logic [3:0]  queue_id,
  input  logic [31:0] payload,
  input  logic [31:0] delay,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [3:0]  slot_out,
  output logic [3:0]  queue_out,
  output logic [31:0] payload_out,
  output logic        last
);

  mst_cmd_t cmd;
  mst_sts_t sts;

  // Sequencing of each transaction.
  mst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot storage, scan and result register.
  mst_datapath #(.SLOTS(SLOTS)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .action      (action),
    .slot        (slot),
    .queue_id    (queue_id),
    .payload     (payload),
    .delay       (delay),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .slot_out    (slot_out),
    .queue_out   (queue_out),
    .payload_out (payload_out),
    .last        (last)
  );

endmodule
